/* rtl/core/utf8_stream_decoder_defines.svh */
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Shared property shorthands for the decoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define UTF8_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utf8 decoder check failed");

// Next-cycle implication, disabled while reset is held.
`define UTF8_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8 decoder check failed");

`endif

/* rtl/core/utf8_pkg.sv */
// ----------------------------------------------------------------------------
// utf8_pkg
// Types, byte classes and status codes shared by the UTF-8 decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package utf8_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam int unsigned CpW   = 21;
  localparam int unsigned PartW = 15;

  // Byte classes decided by the front end
  typedef logic [2:0] cls_t;
  localparam cls_t CLS_ASCII = 3'd0;
  localparam cls_t CLS_LEAD2 = 3'd1;
  localparam cls_t CLS_LEAD3 = 3'd2;
  localparam cls_t CLS_LEAD4 = 3'd3;
  localparam cls_t CLS_CONT  = 3'd4;
  localparam cls_t CLS_BAD   = 3'd5;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BAD_LEAD = 2'd1;
  localparam status_t ST_BAD_CONT = 2'd2;
  localparam status_t ST_TRUNC    = 2'd3;

  // One classified byte as it travels through the queue
  typedef struct packed {
    cls_t       cls;
    logic [6:0] bits;   // payload bits, already masked for the class
    logic       fin;
  } entry_t;

endpackage
`default_nettype wire

/* rtl/core/utf8_front.sv */
// ----------------------------------------------------------------------------
// utf8_front
// Accept bytes and classify them by prefix into ASCII, lead, continuation or bad.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module utf8_front
  import utf8_pkg::*;
(
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_stream_end,
  input  logic       q_full,
  output logic       push,
  output entry_t     push_entry
);

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_entry.fin = in_stream_end;
    priority if (in_byte[7] == 1'b0) begin
      push_entry.cls  = CLS_ASCII;
      push_entry.bits = in_byte[6:0];
    end else if (in_byte[7:6] == 2'b10) begin
      push_entry.cls  = CLS_CONT;
      push_entry.bits = {1'b0, in_byte[5:0]};
    end else if (in_byte[7:5] == 3'b110) begin
      push_entry.cls  = CLS_LEAD2;
      push_entry.bits = {2'b00, in_byte[4:0]};
    end else if (in_byte[7:4] == 4'b1110) begin
      push_entry.cls  = CLS_LEAD3;
      push_entry.bits = {3'b000, in_byte[3:0]};
    end else if (in_byte[7:3] == 5'b11110) begin
      push_entry.cls  = CLS_LEAD4;
      push_entry.bits = {4'b0000, in_byte[2:0]};
    end else begin
      push_entry.cls  = CLS_BAD;
      push_entry.bits = '0;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/utf8_queue.sv */
// ----------------------------------------------------------------------------
// utf8_queue
// Short FIFO of classified bytes between front end and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_decoder_defines.svh"
module utf8_queue
  import utf8_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   q_valid,
  output entry_t q_entry
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t        mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_entry = mem_r[rd_ptr_r];

  // advance with wrap at the last slot
  assign wr_ptr_nxt = !push ? wr_ptr_r :
                      (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = !pop ? rd_ptr_r :
                      (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `UTF8_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !full)
  `UTF8_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, q_valid)

endmodule
`default_nettype wire

/* rtl/core/utf8_back.sv */
// ----------------------------------------------------------------------------
// utf8_back
// Sequence state and code point assembly, with a registered result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_decoder_defines.svh"
module utf8_back
  import utf8_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  entry_t         q_entry,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [CpW-1:0] out_scalar,
  output status_t        out_status,
  output logic           out_final_item
);

  logic [1:0]       bytes_left_r, bytes_left_nxt;
  logic [PartW-1:0] partial_r, partial_nxt;
  logic             out_valid_r;
  logic [CpW-1:0]   cp_r;
  status_t          status_r;
  logic             fin_r;

  logic             emit;
  logic [CpW-1:0]   emit_cp;
  status_t          emit_status;
  logic             emit_fin;
  logic [CpW-1:0]   cont_cp;

  // take an entry when the result stage is free or being drained
  assign pop = q_valid && (!out_valid_r || !out_stall);

  assign cont_cp = {partial_r, q_entry.bits[5:0]};

  always_comb begin
    emit           = 1'b0;
    emit_cp        = '0;
    emit_status    = ST_OK;
    emit_fin       = q_entry.fin;
    bytes_left_nxt = bytes_left_r;
    partial_nxt    = partial_r;
    if (bytes_left_r == 2'd0) begin
      unique case (q_entry.cls)
        CLS_ASCII: begin
          emit    = 1'b1;
          emit_cp = CpW'(q_entry.bits);
        end
        CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
          if (q_entry.fin) begin
            emit        = 1'b1;
            emit_status = ST_TRUNC;
          end else begin
            partial_nxt    = PartW'(q_entry.bits);
            bytes_left_nxt = (q_entry.cls == CLS_LEAD2) ? 2'd1 :
                             (q_entry.cls == CLS_LEAD3) ? 2'd2 : 2'd3;
          end
        end
        default: begin
          emit        = 1'b1;
          emit_status = ST_BAD_LEAD;
        end
      endcase
    end else if (q_entry.cls != CLS_CONT) begin
      emit        = 1'b1;
      emit_status = ST_BAD_CONT;
    end else if (bytes_left_r == 2'd1) begin
      emit    = 1'b1;
      emit_cp = cont_cp;
    end else if (q_entry.fin) begin
      emit        = 1'b1;
      emit_status = ST_TRUNC;
    end else begin
      partial_nxt    = cont_cp[PartW-1:0];
      bytes_left_nxt = bytes_left_r - 2'd1;
    end
    // any result drops the partial sequence
    if (emit) begin
      bytes_left_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= 2'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (pop) begin
        bytes_left_r <= bytes_left_nxt;
        out_valid_r  <= emit;
      end else if (!out_stall) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      partial_r <= partial_nxt;
      if (emit) begin
        cp_r     <= emit_cp;
        status_r <= emit_status;
        fin_r    <= emit_fin;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_scalar     = cp_r;
  assign out_status     = status_r;
  assign out_final_item = fin_r;

  `UTF8_ASSERT_IMP(a_err_zero_cp, clk, rst_n,
                   out_valid_r && (status_r != ST_OK), cp_r == '0)
  `UTF8_ASSERT_IMP(a_trunc_final, clk, rst_n,
                   out_valid_r && (status_r == ST_TRUNC), fin_r)
  `UTF8_ASSERT_NXT(a_result_clears, clk, rst_n, pop && emit, bytes_left_r == 2'd0)

endmodule
`default_nettype wire

/* rtl/core/utf8_stream_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to code point decoder, one byte per cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one byte per item, with
//   in_stream_end marking the last byte of a stream.
//   Result channel (out_valid / out_stall): a code point with a status
//   (ok, bad lead, bad continuation, truncated) and out_final_item.
//   Bytes in the middle of a sequence produce no result item.
//   The byte that completes a sequence is written into the queue, then the
//   back-end step takes it into the result register, from which the result
//   is offered.
//   Throughput: one byte per cycle while out_stall is low, set by the
//   back-end step and the one-entry-per-cycle queue port.
//   Reset (rst_n low, synchronous): empty queue, no pending result, and the
//   decoder expects a lead byte.
//   Receiver stall: the result register holds; the back end stops popping
//   and the queue fills, after which in_stall rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module utf8_stream_decoder
  import utf8_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  // byte input
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_byte,
  input  logic           in_stream_end,
  // result output
  output logic           out_valid,
  input  logic           out_stall,
  output logic [CpW-1:0] out_scalar,
  output logic [1:0]     out_status,
  output logic           out_final_item
);

  logic   q_full;
  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   q_valid;
  entry_t q_entry;

  // Front end: classify each byte by its prefix and mask its payload
  utf8_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_stream_end (in_stream_end),
    .q_full        (q_full),
    .push          (push),
    .push_entry    (push_entry)
  );

  // Decouple classification from sequence assembly
  utf8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  // Back end: track the sequence, assemble code points, hold the result
  utf8_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_entry        (q_entry),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_scalar     (out_scalar),
    .out_status     (out_status),
    .out_final_item (out_final_item)
  );

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Feeds byte streams (directed edge cases, then random well-formed and
// corrupted sequences) through the decoder under several idle and stall
// mixes, and checks every decoded item against the table's own answers or an in-bench decoder model.
// ----------------------------------------------------------------------------
module testbench;
  import utf8_pkg::*;

  // Watchdog: cycles in a row with no item moving on either channel
  localparam int unsigned HangLimit = 5000;
  localparam int unsigned ItemsPerPhase = 325;
  localparam int unsigned DirRows = 26;
  // Result offered once the completing byte passes the queue and the back end; leave some slack
  localparam int unsigned DrainCycles = 8;

  // One decoded item as it leaves the block
  typedef struct packed {
    logic [CpW-1:0] scalar;
    status_t        status;
    logic           final_item;
  } decoded_t;

  // One row of the directed stimulus; typed rows carry their own answer
  typedef struct packed {
    logic [7:0]     b;
    logic           e;
    logic           typed;
    logic           has;
    logic [CpW-1:0] cp;
    status_t        st;
  } dir_row_t;

  localparam dir_row_t DirTable [DirRows] = '{
    // ASCII extremes
    '{8'h00, 1'b0, 1'b1, 1'b1, 21'h000000, ST_OK},
    '{8'h7F, 1'b0, 1'b1, 1'b1, 21'h00007F, ST_OK},
    // stray continuation and 11111xxx in lead position
    '{8'h80, 1'b0, 1'b1, 1'b1, 21'h000000, ST_BAD_LEAD},
    '{8'hF8, 1'b0, 1'b1, 1'b1, 21'h000000, ST_BAD_LEAD},
    // two, three and four byte forms, up to the largest code point
    '{8'hC3, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
    '{8'hA9, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
    '{8'hE2, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
    '{8'h82, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
    '{8'hAC, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
    '{8'hF4, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
    '{8'h8F, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
    '{8'hBF, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
    '{8'hBF, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
    '{8'hF7, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
    '{8'hBF, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
    '{8'hBF, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
    '{8'hBF, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
    // ASCII where a continuation belongs: dropped, not retried as a lead
    '{8'hC2, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
    '{8'h41, 1'b0, 1'b1, 1'b1, 21'h000000, ST_BAD_CONT},
    // stream ends inside a sequence, on a continuation and on a lead
    '{8'hE0, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
    '{8'h80, 1'b1, 1'b1, 1'b1, 21'h000000, ST_TRUNC},
    '{8'hC0, 1'b1, 1'b1, 1'b1, 21'h000000, ST_TRUNC},
    // bad byte on the last byte reports its own error, not truncation
    '{8'hC2, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
    '{8'hC2, 1'b1, 1'b1, 1'b1, 21'h000000, ST_BAD_CONT},
    '{8'hFF, 1'b1, 1'b1, 1'b1, 21'h000000, ST_BAD_LEAD},
    '{8'h41, 1'b1, 1'b1, 1'b1, 21'h000041, ST_OK}
  };

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  logic [7:0]     in_byte;
  logic           in_stream_end;
  logic           out_valid;
  logic           out_stall;
  logic [CpW-1:0] out_scalar;
  logic [1:0]     out_status;
  logic           out_final_item;

  // Decoder model state
  logic [PartW-1:0] seq_partial;
  logic [1:0]       seq_left;

  decoded_t awaited_items [$];
  logic [7:0] stream_bytes [$];
  logic       stream_ends [$];

  int unsigned fail_count;
  int unsigned quiet_cycles;
  int unsigned idle_pct;
  int unsigned stall_pct;

  utf8_stream_decoder uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_stream_end  (in_stream_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_scalar     (out_scalar),
    .out_status     (out_status),
    .out_final_item (out_final_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Decode one byte; returns 1 when it yields an item. Any item drops
  // the partial sequence, so clear first and restore only on the quiet paths.
  function automatic bit decode_byte(input logic [7:0] b, input logic e,
                                     output decoded_t r);
    logic [PartW-1:0] part;
    logic [1:0]       left;
    logic [CpW-1:0]   acc;
    part = seq_partial;
    left = seq_left;
    seq_partial = '0;
    seq_left = 2'd0;
    r = '{scalar: '0, status: ST_OK, final_item: e};
    if (left == 2'd0) begin
      if (!b[7]) begin
        r.scalar = CpW'(b);
        return 1'b1;
      end
      if (b[7:5] == 3'b110) begin
        part = PartW'(b[4:0]);
        left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        part = PartW'(b[3:0]);
        left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        part = PartW'(b[2:0]);
        left = 2'd3;
      end else begin
        r.status = ST_BAD_LEAD;
        return 1'b1;
      end
      if (e) begin
        r.status = ST_TRUNC;
        return 1'b1;
      end
      seq_partial = part;
      seq_left = left;
      return 1'b0;
    end
    if (b[7:6] != 2'b10) begin
      r.status = ST_BAD_CONT;
      return 1'b1;
    end
    acc = {part, b[5:0]};
    if (left == 2'd1) begin
      r.scalar = acc;
      return 1'b1;
    end
    if (e) begin
      r.status = ST_TRUNC;
      return 1'b1;
    end
    seq_partial = acc[PartW-1:0];
    seq_left = left - 2'd1;
    return 1'b0;
  endfunction

  task automatic note_failure(input string what, input decoded_t want,
                              input decoded_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t %s: expected cp=%06h st=%0d fin=%0b, got cp=%06h st=%0d fin=%0b",
               $realtime, what, want.scalar, want.status, want.final_item,
               got.scalar, got.status, got.final_item);
  endtask

  // Offer one item and hold it until it is taken. Stall is sampled at the
  // falling edge, where every signal it depends on has settled.
  task automatic send_byte(input logic [7:0] b, input logic e, input bit typed,
                           input bit has, input decoded_t typed_r);
    decoded_t r;
    bit got;
    bit taken;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_stream_end <= e;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    got = decode_byte(b, e, r);
    // Typed rows answer for themselves; the model still advances
    if (typed) begin
      if (has)
        awaited_items.push_back(typed_r);
    end else if (got) begin
      awaited_items.push_back(r);
    end
  endtask

  // Queue one random sequence: mostly well formed, some corrupted,
  // cut short at stream end, or plain noise.
  task automatic queue_sequence();
    logic [CpW-1:0] cp;
    logic [7:0]     seq [4];
    logic [7:0]     junk;
    int             n;
    int             k;
    int             pick;
    bit             cut;
    cp = CpW'($urandom);
    n = $urandom_range(1, 4);
    cut = 1'b0;
    case (n)
      1: seq[0] = {1'b0, cp[6:0]};
      2: seq[0] = {3'b110, cp[10:6]};
      3: seq[0] = {4'b1110, cp[15:12]};
      default: seq[0] = {5'b11110, cp[20:18]};
    endcase
    for (k = 1; k < n; k++)
      seq[k] = {2'b10, 6'(cp >> (6 * (n - 1 - k)))};
    pick = $urandom_range(99);
    if (pick < 8 && n > 1) begin
      // corrupt one continuation byte
      junk = 8'($urandom);
      while (junk[7:6] == 2'b10)
        junk = 8'($urandom);
      seq[$urandom_range(1, n - 1)] = junk;
    end else if (pick < 14 && n > 1) begin
      // stream ends before the sequence does
      n = $urandom_range(1, n - 1);
      cut = 1'b1;
    end else if (pick < 22) begin
      seq[0] = 8'($urandom);
      n = 1;
    end else if (pick < 26) begin
      seq[0] = $urandom_range(1) ? {2'b10, 6'($urandom)} : {5'b11111, 3'($urandom)};
      n = 1;
    end
    for (k = 0; k < n; k++) begin
      stream_bytes.push_back(seq[k]);
      stream_ends.push_back(k == n - 1 && (cut || $urandom_range(99) < 8));
    end
  endtask

  // Receiver: stall at the phase's rate
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // Result check, sampled at the falling edge: an item seen here is taken
  // at the next rising edge, since stall is already settled.
  always @(negedge clk) begin
    decoded_t seen;
    decoded_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen = '{scalar: out_scalar, status: status_t'(out_status),
               final_item: out_final_item};
      if (awaited_items.size() == 0) begin
        note_failure("unexpected item", '0, seen);
      end else begin
        want = awaited_items.pop_front();
        if (seen.scalar !== want.scalar || seen.status !== want.status ||
            seen.final_item !== want.final_item)
          note_failure("item mismatch", want, seen);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= HangLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    decoded_t row_r;
    decoded_t left_over;
    int unsigned sent;
    int phase;
    int i;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = 8'h00;
    in_stream_end = 1'b0;
    fail_count = 0;
    quiet_cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    seq_partial = '0;
    seq_left = 2'd0;

    // Hold reset, then release
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: extremes, each status, the corner cases
    for (i = 0; i < DirRows; i++) begin
      row_r = '{scalar: DirTable[i].cp, status: DirTable[i].st,
                final_item: DirTable[i].e};
      send_byte(DirTable[i].b, DirTable[i].e, DirTable[i].typed,
                DirTable[i].has, row_r);
    end

    // Random streams, one idling mix per phase
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 83;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 83;
        end
        default: begin
          idle_pct = 6;
          stall_pct = 6;
        end
      endcase
      sent = 0;
      while (sent < ItemsPerPhase) begin
        queue_sequence();
        while (stream_bytes.size() != 0) begin
          send_byte(stream_bytes.pop_front(), stream_ends.pop_front(), 1'b0, 1'b0, '0);
          sent++;
        end
      end
    end
    in_valid <= 1'b0;

    // Drain: the watchdog catches an item that never shows up
    while (awaited_items.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    while (awaited_items.size() != 0) begin
      left_over = awaited_items.pop_front();
      note_failure("item never delivered", left_over, '0);
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* utf8_stream_decoder.f */
+incdir+rtl/core
rtl/core/utf8_pkg.sv
rtl/core/utf8_front.sv
rtl/core/utf8_queue.sv
rtl/core/utf8_back.sv
rtl/core/utf8_stream_decoder.sv
tb/testbench.sv
